[src/pgpi_pkg.sv]
// Package for the periodic Gaussian pulse injector: transaction payload types,
// command and register codes, reset constants and the profile table generator.
// No dependencies.
package pgpi_pkg;

  localparam int unsigned NUM_CHANNELS_DEF    = 4096;
  localparam int unsigned EXP_TABLE_DEPTH_DEF = 256;

  localparam int unsigned CH_W     = 12;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned NOISE_W  = 12;
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned AMP_W    = 16;
  localparam int unsigned PROF_W   = 16;
  localparam int unsigned IWS_W    = 24;
  localparam int unsigned CFG_W    = 32;

  // Half of one pulse period in Q0.32, the center of the pulse.
  localparam logic [PHASE_W-1:0] HALF_PHASE = 32'h8000_0000;
  // exp(-1/16) in Q0.32: one table step is 1/16 of the exponent.
  localparam logic [63:0] EXP_STEP = 64'd4034748382;
  localparam logic [IWS_W-1:0] INV_WIDTH_SQ_RST = 24'd102400;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_LOAD   = 1'b1
  } cmd_t;

  typedef enum logic {
    CFG_PHASE_STEP   = 1'b0,
    CFG_INV_WIDTH_SQ = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    cmd_t                       cmd;
    logic [CH_W-1:0]            channel;
    logic [SAMPLE_W-1:0]        sample;
    logic signed [NOISE_W-1:0]  noise;
    logic [PHASE_W-1:0]         load_phase;
    logic [AMP_W-1:0]           load_amplitude;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]     out_channel;
    logic [SAMPLE_W-1:0] injected_sample;
    logic                clipped;
  } out_item_t;

  // Per-item context that rides along the arithmetic pipeline.
  typedef struct packed {
    logic [CH_W-1:0]           channel;
    logic [SAMPLE_W-1:0]       sample;
    logic signed [NOISE_W-1:0] noise;
  } ctx_t;

  // Entry k of the Q0.16 profile table, exp(-k/16), built by repeated
  // multiplication in Q0.32. Evaluated at elaboration only.
  function automatic logic [PROF_W-1:0] prof_entry(input int unsigned k);
    logic [63:0] e;
    logic [63:0] v;
    e = 64'h1_0000_0000;
    for (int unsigned i = 0; i < k; i++) begin
      e = (e * EXP_STEP + 64'h8000_0000) >> 32;
    end
    v = (e + 64'd32768) >> 16;
    return (v > 64'd65535) ? 16'hFFFF : v[PROF_W-1:0];
  endfunction

endpackage

[src/periodic_gaussian_pulse_injector.sv]
// Periodic Gaussian pulse injector, top level.
// Depends on pgpi_pkg for payload types, codes and the profile table function.

// The block takes one transaction per cycle unless the pipeline holds. Each
// sample transaction gives a result on the output; load transactions, and
// transactions whose channel is at or above NUM_CHANNELS, give none. The
// channel phase and amplitude live in two single-port-write memories. They are
// read when a transaction is accepted and written back as it leaves the memory
// stage. A transaction on the same channel as the one just ahead takes the
// written-back values through a forwarding register, so back-to-back hits on
// one channel still run at one per cycle unless the pipeline holds. Behind the
// memory stage sit the distance from the pulse center, the squaring
// multiplier, the width multiplier, the profile table, the amplitude
// multiplier and the rounding stage, each followed by a register. The whole
// pipeline holds while a finished result waits at the output register. The
// memories are not cleared: a channel must be loaded before it is sampled,
// and the block is ready right after reset.
module periodic_gaussian_pulse_injector #(
  parameter int unsigned NUM_CHANNELS    = pgpi_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned EXP_TABLE_DEPTH = pgpi_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  pgpi_pkg::in_item_t     in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output pgpi_pkg::out_item_t    out_data,
  input  logic                   cfg_we,
  input  pgpi_pkg::cfg_reg_t     cfg_index,
  input  logic [pgpi_pkg::CFG_W-1:0] cfg_data
);
  import pgpi_pkg::*;

  localparam int unsigned ADDR_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned TBL_W   = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned X16_W   = 21;
  localparam int unsigned SUM_W   = 35;

  // Configuration registers.
  logic [PHASE_W-1:0] phase_step_r;
  logic [IWS_W-1:0]   inv_width_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r   <= '0;
      inv_width_sq_r <= INV_WIDTH_SQ_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PHASE_STEP:   phase_step_r   <= cfg_data[PHASE_W-1:0];
        CFG_INV_WIDTH_SQ: inv_width_sq_r <= cfg_data[IWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Profile table, a constant array.
  logic [PROF_W-1:0] prof_tbl [EXP_TABLE_DEPTH];

  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_tbl
    localparam logic [PROF_W-1:0] ENTRY = prof_entry(k);
    assign prof_tbl[k] = ENTRY;
  end

  // Pipeline control: every stage moves when the output register is free.
  logic adv;
  logic in_fire;
  logic ch_ok;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign in_fire  = in_valid && in_ready;
  assign ch_ok    = ({20'd0, in_data.channel} < NUM_CHANNELS);

  logic [ADDR_W-1:0] in_addr;
  assign in_addr = ADDR_W'(in_data.channel);

  // Channel state memories.
  logic [PHASE_W-1:0] phase_mem [NUM_CHANNELS];
  logic [AMP_W-1:0]   amp_mem   [NUM_CHANNELS];

  logic [PHASE_W-1:0] rd_phase_r;
  logic [AMP_W-1:0]   rd_amp_r;

  // Stage 1: memory read data and write-back.
  logic               s1_valid_r;
  in_item_t           s1_item_r;
  logic               fwd_hit_r;
  logic [PHASE_W-1:0] fwd_phase_r;
  logic [AMP_W-1:0]   fwd_amp_r;

  logic [PHASE_W-1:0] eff_phase;
  logic [AMP_W-1:0]   eff_amp;
  logic [PHASE_W-1:0] new_phase;
  logic [AMP_W-1:0]   new_amp;
  logic [PHASE_W-1:0] dist_nxt;
  logic               mem_we;
  logic [ADDR_W-1:0]  s1_addr;

  assign eff_phase = fwd_hit_r ? fwd_phase_r : rd_phase_r;
  assign eff_amp   = fwd_hit_r ? fwd_amp_r   : rd_amp_r;
  assign s1_addr   = ADDR_W'(s1_item_r.channel);
  assign mem_we    = s1_valid_r && adv;

  always_comb begin
    unique case (s1_item_r.cmd)
      CMD_LOAD: begin
        new_phase = s1_item_r.load_phase;
        new_amp   = s1_item_r.load_amplitude;
      end
      CMD_SAMPLE: begin
        new_phase = eff_phase + phase_step_r;
        new_amp   = eff_amp;
      end
      default: begin
        new_phase = eff_phase;
        new_amp   = eff_amp;
      end
    endcase
  end

  // Distance of the phase from the pulse center.
  assign dist_nxt = eff_phase[PHASE_W-1] ? (eff_phase - HALF_PHASE)
                                         : (HALF_PHASE - eff_phase);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      phase_mem[s1_addr] <= new_phase;
    end
    if (in_fire) begin
      rd_phase_r <= phase_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      amp_mem[s1_addr] <= new_amp;
    end
    if (in_fire) begin
      rd_amp_r <= amp_mem[in_addr];
    end
  end

  // A transaction accepted while its channel is being written back reads the
  // old memory word, so the new values are kept for it here.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r   <= in_data;
      fwd_hit_r   <= s1_valid_r && (s1_item_r.channel == in_data.channel);
      fwd_phase_r <= new_phase;
      fwd_amp_r   <= new_amp;
    end
  end

  // Arithmetic stages 2 to 6.
  logic [6:2]         vld_r;
  ctx_t               ctx_r [2:6];
  logic [AMP_W-1:0]   amp_r [2:5];
  logic [PHASE_W-1:0] dist_r;
  logic [PHASE_W-1:0] sq_r;
  logic [PHASE_W+IWS_W-1:0] wprod_r;
  logic [PROF_W-1:0]  prof_r;
  logic [AMP_W+PROF_W-1:0] ap_r;

  logic [2*PHASE_W-1:0]      sq_full;
  logic [PHASE_W+IWS_W:0]    wprod_rnd;
  logic [X16_W-1:0]          x16;
  logic                      x16_in;
  logic [PROF_W-1:0]         prof;

  assign sq_full   = 64'(dist_r) * 64'(dist_r);
  assign wprod_rnd = {1'b0, wprod_r} + (57'd1 << 35);
  assign x16       = wprod_rnd[PHASE_W+IWS_W:36];
  assign x16_in    = (32'(x16) < EXP_TABLE_DEPTH);
  assign prof      = x16_in ? prof_tbl[x16[TBL_W-1:0]] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      vld_r      <= '0;
    end else if (adv) begin
      s1_valid_r <= in_fire && ch_ok;
      vld_r[2]   <= s1_valid_r && (s1_item_r.cmd == CMD_SAMPLE);
      vld_r[6:3] <= vld_r[5:2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx_r[2] <= '{channel: s1_item_r.channel, sample: s1_item_r.sample,
                    noise: s1_item_r.noise};
      amp_r[2] <= eff_amp;
      dist_r   <= dist_nxt;
      for (int i = 3; i <= 6; i++) begin
        ctx_r[i] <= ctx_r[i-1];
      end
      for (int i = 3; i <= 5; i++) begin
        amp_r[i] <= amp_r[i-1];
      end
      sq_r    <= sq_full[2*PHASE_W-1:PHASE_W];
      wprod_r <= 56'(sq_r) * 56'(inv_width_sq_r);
      prof_r  <= prof;
      ap_r    <= 32'(amp_r[5]) * 32'(prof_r);
    end
  end

  // Stage 6: sum in Q.24, round half away from zero, saturate.
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_rnd;
  logic [10:0]             r_pos;
  logic                    neg;
  logic                    clip_lo;
  logic                    clip_hi;
  out_item_t               res;

  assign sum = $signed({3'b000, ctx_r[6].sample, 24'd0})
             + $signed({3'b000, ap_r})
             + $signed({{7{ctx_r[6].noise[NOISE_W-1]}}, ctx_r[6].noise, 16'd0});
  assign sum_rnd = sum + 35'sd8388608;
  assign r_pos   = sum_rnd[SUM_W-1:24];
  assign neg     = sum[SUM_W-1];
  assign clip_lo = neg && (sum <= -35'sd8388608);
  assign clip_hi = !neg && (r_pos > 11'd255);

  always_comb begin
    res.out_channel = ctx_r[6].channel;
    res.clipped     = clip_lo || clip_hi;
    priority if (neg) begin
      res.injected_sample = '0;
    end else if (clip_hi) begin
      res.injected_sample = 8'hFF;
    end else begin
      res.injected_sample = r_pos[SAMPLE_W-1:0];
    end
  end

  logic out_valid_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A saturated result can only sit at one of the two rails.
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.clipped |->
      (out_data_r.injected_sample == 8'h00) || (out_data_r.injected_sample == 8'hFF))
    else $error("clipped result not at a rail");

  // A sample transaction leaving the memory stage enters the arithmetic pipe.
  a_sample_enters: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_valid_r && (s1_item_r.cmd == CMD_SAMPLE) |=> vld_r[2])
    else $error("sample transaction lost after memory stage");

  // A back-to-back hit on the channel being written back must use forwarding.
  a_fwd_hit: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && s1_valid_r && (s1_item_r.channel == in_data.channel) |=> fwd_hit_r)
    else $error("missed forwarding on same-channel transaction");

endmodule

[verif/tb_periodic_gaussian_pulse_injector.sv]
// Self-checking testbench for periodic_gaussian_pulse_injector: predicts every injected sample
// from its own channel stores and profile table and compares each result transaction in order.
// Depends on pgpi_pkg and the periodic_gaussian_pulse_injector RTL.
`timescale 1ns / 1ps

module tb_periodic_gaussian_pulse_injector;
  import pgpi_pkg::*;

  localparam int unsigned LUT_DEPTH   = EXP_TABLE_DEPTH_DEF;
  localparam logic [31:0] PULSE_CENTER = 32'h8000_0000;
  localparam logic [63:0] DECAY       = 64'd4034748382;
  localparam longint     ROUND_HALF   = 64'sd8388608;
  localparam int         DRAIN_LIMIT  = 5000;
  localparam int         RAND_PER_SET = 100;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                cfg_we;
  cfg_reg_t            cfg_index;
  logic [CFG_W-1:0]    cfg_data;

  // Predictor state: register copies, channel stores and the profile table.
  logic [31:0]         step_cfg = 32'd0;
  logic [23:0]         iws_cfg  = 24'd102400;
  logic [31:0]         phase_store [NUM_CHANNELS_DEF];
  logic [15:0]         amp_store   [NUM_CHANNELS_DEF];
  logic [15:0]         gauss_lut   [LUT_DEPTH];

  out_item_t           awaited_samples[$];
  logic [11:0]         live_ch[$];
  bit                  seen_load [NUM_CHANNELS_DEF];
  logic [11:0]         last_load;
  bit                  no_gaps = 1'b0;

  int errors = 0;
  int n_loads = 0;
  int n_samples = 0;
  int n_clipped = 0;
  int n_settings = 0;

  periodic_gaussian_pulse_injector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Entry k holds exp(-k/16) in Q0.16, stepped down by repeated Q0.32 multiplies.
  initial begin : lut_build
    logic [63:0] e;
    logic [63:0] v;
    e = 64'h1_0000_0000;
    for (int k = 0; k < LUT_DEPTH; k++) begin
      v = (e + 64'd32768) >> 16;
      gauss_lut[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      e = (e * DECAY + 64'h8000_0000) >> 32;
    end
  end

  function automatic logic [15:0] pulse_profile(input logic [31:0] ph);
    logic [31:0] off;
    logic [63:0] sq;
    logic [63:0] idx;
    off = ph[31] ? ph - PULSE_CENTER : PULSE_CENTER - ph;
    sq = ({32'd0, off} * {32'd0, off}) >> 32;
    idx = (sq * {40'd0, iws_cfg} + 64'h8_0000_0000) >> 36;
    return (idx < LUT_DEPTH) ? gauss_lut[idx[7:0]] : 16'd0;
  endfunction

  // Applies one accepted transaction to the channel stores; returns 1 with the
  // expected result when the transaction is a sample.
  function automatic bit predict_injection(input in_item_t it, output out_item_t res);
    logic [31:0] ph;
    logic [15:0] prof;
    longint      sum;
    longint      rnd;
    res = '0;
    if (it.cmd == CMD_LOAD) begin
      phase_store[it.channel] = it.load_phase;
      amp_store[it.channel] = it.load_amplitude;
      return 1'b0;
    end
    ph = phase_store[it.channel];
    prof = pulse_profile(ph);
    sum = (longint'(it.sample) <<< 24)
        + longint'(amp_store[it.channel]) * longint'(prof)
        + longint'(signed'(it.noise)) * 64'sd65536;
    // Round half away from zero, so negative sums round on their magnitude.
    if (sum >= 0) begin
      rnd = (sum + ROUND_HALF) >>> 24;
    end else begin
      rnd = -((-sum + ROUND_HALF) >>> 24);
    end
    res.out_channel = it.channel;
    if (rnd < 0) begin
      res.injected_sample = 8'd0;
      res.clipped = 1'b1;
    end else if (rnd > 255) begin
      res.injected_sample = 8'd255;
      res.clipped = 1'b1;
    end else begin
      res.injected_sample = rnd[7:0];
      res.clipped = 1'b0;
    end
    phase_store[it.channel] = ph + step_cfg;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : scoreboard
    out_item_t want;
    out_item_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (awaited_samples.size() == 0) begin
          $error("result on channel %0d with no expected transaction", got.out_channel);
          errors++;
        end else begin
          want = awaited_samples.pop_front();
          if (got.out_channel !== want.out_channel) begin
            $error("out_channel: expected %0d, got %0d", want.out_channel, got.out_channel);
            errors++;
          end
          if (got.injected_sample !== want.injected_sample) begin
            $error("injected_sample: expected %0d, got %0d", want.injected_sample,
                   got.injected_sample);
            errors++;
          end
          if (got.clipped !== want.clipped) begin
            $error("clipped: expected %0d, got %0d", want.clipped, got.clipped);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.cmd == CMD_LOAD) n_loads++;
        else n_samples++;
        if (predict_injection(in_data, want)) begin
          awaited_samples.insert(awaited_samples.size(), want);
          if (want.clipped) n_clipped++;
        end
      end
    end
  end

  // Result side: short random stalls, occasional long ones, none while no_gaps is set.
  initial begin : out_stall_proc
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (no_gaps) begin
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
        stall = $urandom_range(8, 30);
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) < 75);
      end
    end
  end

  initial begin
    #2000000;
    $display("tb_periodic_gaussian_pulse_injector: done, errors");
    $finish;
  end

  function automatic in_item_t item_of(input cmd_t cmd, input logic [11:0] ch,
                                       input logic [7:0] smp, input logic signed [11:0] nz,
                                       input logic [31:0] ph, input logic [15:0] amp);
    in_item_t it;
    it.cmd = cmd;
    it.channel = ch;
    it.sample = smp;
    it.noise = nz;
    it.load_phase = ph;
    it.load_amplitude = amp;
    return it;
  endfunction

  // Sends one transaction after a random gap, none while no_gaps is set, and returns at the edge that accepts it.
  task automatic send_item(input in_item_t it);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(6, 24);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    if (it.cmd == CMD_LOAD) begin
      last_load = it.channel;
      if (!seen_load[it.channel]) begin
        seen_load[it.channel] = 1'b1;
        live_ch.insert(live_ch.size(), it.channel);
      end
    end
    do @(posedge clk); while (!in_ready);
  endtask

  // Drops valid, waits for every expected result, then lets the pipeline run dry.
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (awaited_samples.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_samples.size() != 0) begin
      $error("%0d expected results never arrived", awaited_samples.size());
      errors++;
      awaited_samples.delete();
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_PHASE_STEP) step_cfg = val;
    else iws_cfg = val[23:0];
    n_settings++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Loads are biased toward a few channels at both ends of the range, phases toward
  // the pulse, and samples often hit the channel loaded last to exercise forwarding.
  function automatic in_item_t random_item();
    in_item_t    it;
    logic [11:0] ch;
    int          r;
    r = $urandom_range(0, 99);
    it.sample = (r < 25) ? 8'd0 : (r < 50) ? 8'd255 : 8'($urandom);
    r = $urandom_range(0, 99);
    it.noise = (r < 10) ? -12'sd2048 : (r < 20) ? 12'sd2047 : 12'($urandom);
    if ($urandom_range(0, 1)) begin
      it.load_phase = PULSE_CENTER + 32'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
    end else begin
      it.load_phase = $urandom;
    end
    r = $urandom_range(0, 99);
    if (r < 30) it.load_amplitude = 16'($urandom);
    else if (r < 60) it.load_amplitude = 16'($urandom_range(0, 16'h03FF));
    else if (r < 80) it.load_amplitude = 16'hFFFF - 16'($urandom_range(0, 16'h0FFF));
    else it.load_amplitude = 16'd0;
    if (live_ch.size() == 0 || $urandom_range(0, 99) < 20) begin
      it.cmd = CMD_LOAD;
      if ($urandom_range(0, 1)) begin
        ch = $urandom_range(0, 1) ? 12'($urandom_range(0, 3)) : 12'(4095 - $urandom_range(0, 3));
      end else begin
        ch = 12'($urandom);
      end
    end else begin
      it.cmd = CMD_SAMPLE;
      if ($urandom_range(0, 99) < 40) ch = last_load;
      else ch = live_ch[$urandom_range(0, live_ch.size() - 1)];
    end
    it.channel = ch;
    return it;
  endfunction

  task automatic test_directed_extremes();
    // Pulse center with full amplitude pushes the sum past the top.
    send_item(item_of(CMD_LOAD, 12'd0, 8'd0, 12'sd0, PULSE_CENTER, 16'hFFFF));
    send_item(item_of(CMD_SAMPLE, 12'd0, 8'd255, 12'sd2047, 32'd0, 16'd0));
    send_item(item_of(CMD_SAMPLE, 12'd0, 8'd0, -12'sd2048, 32'd0, 16'd0));
    send_item(item_of(CMD_LOAD, 12'd4095, 8'd0, 12'sd0, 32'd0, 16'd0));
    send_item(item_of(CMD_SAMPLE, 12'd4095, 8'd0, -12'sd2048, 32'hFFFF_FFFF, 16'hFFFF));
    // Exact halves round away from zero; just under a half rounds to zero.
    send_item(item_of(CMD_SAMPLE, 12'd4095, 8'd0, -12'sd128, 32'd0, 16'd0));
    send_item(item_of(CMD_SAMPLE, 12'd4095, 8'd10, 12'sd128, 32'd0, 16'd0));
    send_item(item_of(CMD_SAMPLE, 12'd4095, 8'd255, 12'sd0, 32'd0, 16'd0));
    send_item(item_of(CMD_SAMPLE, 12'd4095, 8'd255, 12'sd128, 32'd0, 16'd0));
    send_item(item_of(CMD_SAMPLE, 12'd4095, 8'd0, -12'sd127, 32'd0, 16'd0));
    send_item(item_of(CMD_LOAD, 12'hAAA, 8'd0, 12'sd0, 32'hFFFF_FFFF, 16'h0001));
    send_item(item_of(CMD_SAMPLE, 12'hAAA, 8'h55, 12'sd0, 32'd0, 16'd0));
    send_item(item_of(CMD_LOAD, 12'h555, 8'hFF, -12'sd1, 32'h7FFF_FFFF, 16'h8000));
    send_item(item_of(CMD_SAMPLE, 12'h555, 8'h80, 12'sd0, 32'd0, 16'd0));
    // A reload and then, as the next transaction, a sample on the same channel.
    send_item(item_of(CMD_LOAD, 12'd0, 8'd0, 12'sd0, 32'h4CCC_CCCD, 16'h1234));
    send_item(item_of(CMD_SAMPLE, 12'd0, 8'd100, 12'sd0, 32'd0, 16'd0));
    settle();
  endtask

  task automatic test_register_extremes();
    // A zero width term keeps every phase at the pulse peak.
    cfg_write(CFG_PHASE_STEP, 32'h1000_0000);
    cfg_write(CFG_INV_WIDTH_SQ, 32'd0);
    no_gaps = 1'b1;
    send_item(item_of(CMD_LOAD, 12'd7, 8'd0, 12'sd0, 32'd0, 16'h4000));
    repeat (4) send_item(item_of(CMD_SAMPLE, 12'd7, 8'd20, 12'sd0, 32'd0, 16'd0));
    settle();
    no_gaps = 1'b0;
    cfg_write(CFG_PHASE_STEP, 32'hFFFF_FFFF);
    cfg_write(CFG_INV_WIDTH_SQ, 32'h00FF_FFFF);
    send_item(item_of(CMD_LOAD, 12'h800, 8'd0, 12'sd0, PULSE_CENTER, 16'hFFFF));
    repeat (3) send_item(item_of(CMD_SAMPLE, 12'h800, 8'd1, 12'sd0, 32'd0, 16'd0));
    settle();
  endtask

  task automatic test_random_settings();
    logic [31:0] step;
    logic [31:0] iws;
    for (int s = 0; s < 7; s++) begin
      case (s)
        0: begin step = 32'h0100_0000; iws = 32'd102400;   end
        1: begin step = 32'hFFFF_FFFF; iws = 32'h00FF_FFFF; end
        2: begin step = 32'd0;         iws = 32'd0;         end
        3: begin step = $urandom;      iws = $urandom_range(0, 24'h0F_FFFF); end
        4: begin step = 32'h8000_0000; iws = 32'd409600;   end
        5: begin step = $urandom;      iws = $urandom_range(0, 24'hFF_FFFF); end
        default: begin step = 32'd1;   iws = 32'd25600;    end
      endcase
      cfg_write(CFG_PHASE_STEP, step);
      cfg_write(CFG_INV_WIDTH_SQ, iws);
      no_gaps = (s == 3) || ($urandom_range(0, 5) == 0);
      repeat (RAND_PER_SET) send_item(random_item());
      settle();
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_PHASE_STEP;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_extremes();
    test_register_extremes();
    test_random_settings();
    $display("Covered %0d load and %0d sample transactions over %0d register writes.",
             n_loads, n_samples, n_settings);
    $display("%0d of the expected samples were saturated.", n_clipped);
    if (errors == 0) begin
      $display("tb_periodic_gaussian_pulse_injector: done, clean");
    end else begin
      $display("tb_periodic_gaussian_pulse_injector: done, errors");
    end
    $finish;
  end

endmodule
